// File: hdl/str_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the score threshold replacement block
// no dependencies

package str_pkg;

  localparam int WAYS       = 8;
  localparam int IDX_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W      = $clog2(WAYS + 1);
  localparam int SCORE_W    = 8;
  localparam int WAY_W      = 3;
  localparam int KIND_W     = 2;
  localparam int REASON_W   = 2;
  localparam int RND_W      = 8;
  localparam int RND_CNT_W  = $clog2(RND_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_TOUCH  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_INVAL  = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_e;

  typedef enum logic [REASON_W-1:0] {
    REASON_INVALID = 2'd0,
    REASON_RANDOM  = 2'd1,
    REASON_LOWEST  = 2'd2
  } reason_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_MAX  = 2'd0,
    REG_THRESHOLD  = 2'd1,
    REG_INC_STEP   = 2'd2,
    REG_DEC_STEP   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_PICK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [SCORE_W-1:0] score_max;
    logic [SCORE_W-1:0] threshold;
    logic [SCORE_W-1:0] inc_step;
    logic [SCORE_W-1:0] dec_step;
  } cfg_t;

  typedef struct packed {
    logic               upd;
    logic               rot;
    kind_e              kind;
    logic [WAY_W-1:0]   way;
    logic [SCORE_W-1:0] init;
    logic               decay;
  } cell_cmd_t;

  // way number on the result port keeps its low three bits
  function automatic logic [WAY_W-1:0] to_way(input logic [IDX_W-1:0] idx);
    logic [IDX_W+WAY_W-1:0] ext;
    ext = {{WAY_W{1'b0}}, idx};
    return ext[WAY_W-1:0];
  endfunction

endpackage

// File: hdl/str_req_if.sv
`timescale 1ns / 1ps
// request channel: one transaction per touch, insert, invalidate or victim query
// depends on str_pkg

interface str_req_if;
  logic                        valid;
  logic                        ready;
  logic [str_pkg::KIND_W-1:0]  kind;
  logic [str_pkg::WAY_W-1:0]   way;
  logic [str_pkg::SCORE_W-1:0] initial_score;
  logic                        decay_others;
  logic [str_pkg::RND_W-1:0]   random_pick;

  modport source (output valid, kind, way, initial_score, decay_others, random_pick,
                  input ready);
  modport sink (input valid, kind, way, initial_score, decay_others, random_pick,
                output ready);
endinterface

// File: hdl/str_res_if.sv
`timescale 1ns / 1ps
// result channel: one transaction per victim query
// depends on str_pkg

interface str_res_if;
  logic                         valid;
  logic                         ready;
  logic [str_pkg::WAY_W-1:0]    victim_way;
  logic [str_pkg::REASON_W-1:0] victim_reason;

  modport source (output valid, victim_way, victim_reason, input ready);
  modport sink (input valid, victim_way, victim_reason, output ready);
endinterface

// File: hdl/str_cell.sv
`timescale 1ns / 1ps
// one way of the set: valid bit and score, updated in place or rotated to its neighbour
// depends on str_pkg

module str_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  str_pkg::cell_cmd_t            cmd_i,
  input  str_pkg::cfg_t                 cfg_i,
  input  logic [str_pkg::IDX_W-1:0]     idx_i,
  input  logic                          nb_valid_i,
  input  logic [str_pkg::SCORE_W-1:0]   nb_score_i,
  output logic                          valid_o,
  output logic [str_pkg::SCORE_W-1:0]   score_o
);

  logic                          valid_q, valid_d;
  logic [str_pkg::SCORE_W-1:0]   score_q, score_d;
  logic [str_pkg::SCORE_W:0]     sum;
  logic                          sel;

  assign sum = {1'b0, score_q} + {1'b0, cfg_i.inc_step};
  assign sel = ({{str_pkg::IDX_W{1'b0}}, cmd_i.way} ==
                {{str_pkg::WAY_W{1'b0}}, idx_i});

  always_comb begin
    valid_d = valid_q;
    score_d = score_q;
    if (cmd_i.rot) begin
      valid_d = nb_valid_i;
      score_d = nb_score_i;
    end else if (cmd_i.upd) begin
      if (sel) begin
        case (cmd_i.kind)
          str_pkg::KIND_TOUCH: begin
            if (score_q != cfg_i.score_max) begin
              score_d = (sum > {1'b0, cfg_i.score_max}) ? cfg_i.score_max
                                                        : sum[str_pkg::SCORE_W-1:0];
            end
          end
          str_pkg::KIND_INSERT: begin
            valid_d = 1'b1;
            score_d = cmd_i.decay ? cmd_i.init : '0;
          end
          str_pkg::KIND_INVAL: begin
            valid_d = 1'b0;
            score_d = '0;
          end
          default: begin
          end
        endcase
      end else if (cmd_i.decay && valid_q && (score_q != '0) &&
                   (cmd_i.kind == str_pkg::KIND_TOUCH ||
                    cmd_i.kind == str_pkg::KIND_INSERT)) begin
        // decay saturates at zero
        score_d = (score_q > cfg_i.dec_step) ? score_q - cfg_i.dec_step : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      score_q <= '0;
    end else begin
      valid_q <= valid_d;
      score_q <= score_d;
    end
  end

  assign valid_o = valid_q;
  assign score_o = score_q;

endmodule

// File: hdl/str_rem.sv
`timescale 1ns / 1ps
// restoring remainder unit: random value modulo the eligible count, one bit per cycle
// depends on str_pkg

module str_rem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [str_pkg::RND_W-1:0]     dividend_i,
  input  logic [str_pkg::CNT_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [str_pkg::CNT_W-1:0]     rem_o
);

  logic                            busy_q;
  logic [str_pkg::RND_CNT_W-1:0]   cnt_q;
  logic [str_pkg::RND_W-1:0]       dvd_q;
  logic [str_pkg::CNT_W-1:0]       div_q;
  logic [str_pkg::CNT_W-1:0]       rem_q;
  logic [str_pkg::CNT_W:0]         trial;
  logic [str_pkg::CNT_W:0]         rem_d;

  // partial remainder stays below the divisor, so one compare and subtract per bit
  assign trial = {rem_q, dvd_q[str_pkg::RND_W-1]};
  assign rem_d = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;

  assign done_o = busy_q && (cnt_q == str_pkg::RND_CNT_W'(str_pkg::RND_W - 1));
  assign rem_o  = rem_d[str_pkg::CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d[str_pkg::CNT_W-1:0];
    end
  end

endmodule

// File: hdl/score_threshold_replacement_top.sv
`timescale 1ns / 1ps
// touch, insert and invalidate update the cells in place; ready stays high for the next transaction
// victim query: the ring of cells rotates once past the head, then, only for a random pick,
// the remainder unit divides the random value by the eligible count and the ring rotates
// a second time, then the result is loaded into the output register once that is free;
// ready returns in the same cycle as result valid
// reset clears all valid bits and scores and loads the register defaults 15, 7, 1, 1
// depends on str_pkg, str_req_if, str_res_if, str_cell, str_rem

module score_threshold_replacement_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  str_req_if.sink                           req_i,
  str_res_if.source                         res_o,
  input  logic                              cfg_we_i,
  input  logic [str_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [str_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int IDX_W = str_pkg::IDX_W;
  localparam int CNT_W = str_pkg::CNT_W;
  localparam int SW    = str_pkg::SCORE_W;

  str_pkg::cfg_t      cfg_q;
  str_pkg::cell_cmd_t cmd;
  str_pkg::state_e    state_q, state_d;

  logic                  cell_valid [str_pkg::WAYS];
  logic [SW-1:0]         cell_score [str_pkg::WAYS];

  logic [IDX_W-1:0]      step_q, step_d;
  logic [str_pkg::RND_W-1:0] rnd_q;
  logic                  inv_found_q, inv_found_d;
  logic [IDX_W-1:0]      inv_idx_q, inv_idx_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [SW-1:0]         min_score_q, min_score_d;
  logic [IDX_W-1:0]      min_idx_q, min_idx_d;
  logic [CNT_W-1:0]      pick_q, pick_d;
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      pick_idx_q, pick_idx_d;
  logic [IDX_W-1:0]      res_idx_q, res_idx_d;
  str_pkg::reason_e      res_reason_q, res_reason_d;
  logic                  out_valid_q;
  logic [str_pkg::WAY_W-1:0] out_way_q;
  str_pkg::reason_e      out_reason_q;

  logic                  req_acc;
  logic                  in_range;
  logic                  step_last;
  logic                  head_elig;
  logic                  out_free;
  logic                  out_load;
  logic                  rem_start;
  logic                  rem_done;
  logic [CNT_W-1:0]      rem_val;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_max <= 8'd15;
      cfg_q.threshold <= 8'd7;
      cfg_q.inc_step  <= 8'd1;
      cfg_q.dec_step  <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (str_pkg::cfg_reg_e'(cfg_idx_i))
        str_pkg::REG_SCORE_MAX: cfg_q.score_max <= cfg_data_i;
        str_pkg::REG_THRESHOLD: cfg_q.threshold <= cfg_data_i;
        str_pkg::REG_INC_STEP:  cfg_q.inc_step  <= cfg_data_i;
        str_pkg::REG_DEC_STEP:  cfg_q.dec_step  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign req_i.ready = (state_q == str_pkg::S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign in_range    = ({{IDX_W{1'b0}}, req_i.way} <
                        (IDX_W + str_pkg::WAY_W)'(str_pkg::WAYS));

  assign cmd.upd   = req_acc && (str_pkg::kind_e'(req_i.kind) != str_pkg::KIND_QUERY)
                     && in_range;
  assign cmd.rot   = (state_q == str_pkg::S_SCAN) || (state_q == str_pkg::S_PICK);
  assign cmd.kind  = str_pkg::kind_e'(req_i.kind);
  assign cmd.way   = req_i.way;
  assign cmd.init  = req_i.initial_score;
  assign cmd.decay = req_i.decay_others;

  // ring of cells: each takes its upper neighbour on rotation, cell 0 is the head
  for (genvar k = 0; k < str_pkg::WAYS; k++) begin : g_cell
    str_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .cfg_i      (cfg_q),
      .idx_i      (IDX_W'(k)),
      .nb_valid_i (cell_valid[(k + 1) % str_pkg::WAYS]),
      .nb_score_i (cell_score[(k + 1) % str_pkg::WAYS]),
      .valid_o    (cell_valid[k]),
      .score_o    (cell_score[k])
    );
  end

  str_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rnd_q),
    .divisor_i  (count_d),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  assign step_last = (step_q == IDX_W'(str_pkg::WAYS - 1));
  assign head_elig = (cell_score[0] <= cfg_q.threshold);
  assign out_free  = !out_valid_q || res_o.ready;
  assign out_load  = (state_q == str_pkg::S_DONE) && out_free;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    inv_found_d  = inv_found_q;
    inv_idx_d    = inv_idx_q;
    count_d      = count_q;
    min_score_d  = min_score_q;
    min_idx_d    = min_idx_q;
    pick_d       = pick_q;
    found_d      = found_q;
    pick_idx_d   = pick_idx_q;
    res_idx_d    = res_idx_q;
    res_reason_d = res_reason_q;
    rem_start    = 1'b0;
    unique case (state_q)
      str_pkg::S_IDLE: begin
        if (req_acc && (str_pkg::kind_e'(req_i.kind) == str_pkg::KIND_QUERY)) begin
          state_d     = str_pkg::S_SCAN;
          step_d      = '0;
          inv_found_d = 1'b0;
          count_d     = '0;
          found_d     = 1'b0;
        end
      end
      str_pkg::S_SCAN: begin
        if (!cell_valid[0] && !inv_found_q) begin
          inv_found_d = 1'b1;
          inv_idx_d   = step_q;
        end
        if (head_elig) begin
          count_d = count_q + 1'b1;
        end
        if ((step_q == '0) || (cell_score[0] < min_score_q)) begin
          min_score_d = cell_score[0];
          min_idx_d   = step_q;
        end
        if (step_last) begin
          step_d = '0;
          if (inv_found_d) begin
            res_idx_d    = inv_idx_d;
            res_reason_d = str_pkg::REASON_INVALID;
            state_d      = str_pkg::S_DONE;
          end else if (count_d != '0) begin
            rem_start = 1'b1;
            state_d   = str_pkg::S_DIV;
          end else begin
            res_idx_d    = min_idx_d;
            res_reason_d = str_pkg::REASON_LOWEST;
            state_d      = str_pkg::S_DONE;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      str_pkg::S_DIV: begin
        if (rem_done) begin
          pick_d  = rem_val;
          found_d = 1'b0;
          step_d  = '0;
          state_d = str_pkg::S_PICK;
        end
      end
      str_pkg::S_PICK: begin
        // count down eligible ways until the picked one passes the head
        if (head_elig && !found_q) begin
          if (pick_q == '0) begin
            found_d    = 1'b1;
            pick_idx_d = step_q;
          end else begin
            pick_d = pick_q - 1'b1;
          end
        end
        if (step_last) begin
          step_d       = '0;
          res_idx_d    = pick_idx_d;
          res_reason_d = str_pkg::REASON_RANDOM;
          state_d      = str_pkg::S_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      str_pkg::S_DONE: begin
        if (out_free) begin
          state_d = str_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = str_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= str_pkg::S_IDLE;
      step_q      <= '0;
      inv_found_q <= 1'b0;
      found_q     <= 1'b0;
      count_q     <= '0;
      pick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      inv_found_q <= inv_found_d;
      found_q     <= found_d;
      count_q     <= count_d;
      pick_q      <= pick_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      rnd_q <= req_i.random_pick;
    end
    inv_idx_q    <= inv_idx_d;
    min_score_q  <= min_score_d;
    min_idx_q    <= min_idx_d;
    pick_idx_q   <= pick_idx_d;
    res_idx_q    <= res_idx_d;
    res_reason_q <= res_reason_d;
    if (out_load) begin
      out_way_q    <= str_pkg::to_way(res_idx_q);
      out_reason_q <= res_reason_q;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.victim_way    = out_way_q;
  assign res_o.victim_reason = out_reason_q;

`ifndef SYNTHESIS
  // a result transaction is only raised from the completion state
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == str_pkg::S_DONE))
    else $error("result raised outside completion");

  // the picked position never reaches the eligible count
  a_pick_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == str_pkg::S_PICK) |-> (pick_q < count_q))
    else $error("random pick out of range");

  // the second rotation always finds the picked eligible way
  a_pick_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == str_pkg::S_PICK && step_last) |=> found_q)
    else $error("random pick not found");

  // no new transaction is taken while a query walks the ring
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rot || state_q == str_pkg::S_DIV) |-> !req_acc)
    else $error("request accepted during query");
`endif

endmodule
